// ===== hdl/vcp_pkg.sv =====
// Shared types, codes and constants for the volume control point engine.
`timescale 1ns / 1ps
`default_nettype none

package vcp_pkg;

	// Command codes of an input item
	localparam logic [1:0] CMD_REMOTE     = 2'd0;
	localparam logic [1:0] CMD_LOCAL      = 2'd1;
	localparam logic [1:0] CMD_DISCONNECT = 2'd2;

	// Control point opcodes
	localparam logic [7:0] OP_REL_DOWN        = 8'd0;
	localparam logic [7:0] OP_REL_UP          = 8'd1;
	localparam logic [7:0] OP_UNMUTE_REL_DOWN = 8'd2;
	localparam logic [7:0] OP_UNMUTE_REL_UP   = 8'd3;
	localparam logic [7:0] OP_SET_ABS         = 8'd4;
	localparam logic [7:0] OP_UNMUTE          = 8'd5;
	localparam logic [7:0] OP_MUTE            = 8'd6;

	// Result status codes
	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_NOT_SUPPORTED = 2'd1;
	localparam logic [1:0] ST_BAD_COUNTER   = 2'd2;

	// Configuration register indexes
	localparam logic CFG_STEP_SIZE  = 1'b0;
	localparam logic CFG_NOTIFY_EN  = 1'b1;

	localparam logic [7:0] STEP_RESET  = 8'd1;
	localparam logic [7:0] VOL_MAX     = 8'd255;
	localparam logic [2:0] LEN_MIN     = 3'd2;
	localparam logic [2:0] LEN_ABS_SET = 3'd3;

	typedef struct packed {
		logic [7:0] volume;
		logic       muted;
		logic [7:0] count;
		logic       persist;
	} vcp_state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] opcode;
		logic [7:0] client_counter;
		logic [7:0] operand;
		logic [2:0] length;
		logic       local_mute;
	} vcp_item_t;

	typedef struct packed {
		logic [1:0] status;
		vcp_state_t st;
		logic       notify_state;
		logic       notify_flags;
		logic       event_valid;
	} vcp_result_t;

endpackage

`default_nettype wire

// ===== hdl/vcp_calc.sv =====
// Next-state and result logic for one item of the volume control point engine.
`timescale 1ns / 1ps
`default_nettype none

module vcp_calc (
	input  wire vcp_pkg::vcp_state_t  cur,
	input  wire vcp_pkg::vcp_item_t   item,
	input  wire logic [7:0]           step_size,
	input  wire logic                 notify_en,
	output vcp_pkg::vcp_state_t       nxt,
	output vcp_pkg::vcp_result_t      res,
	output logic                      disconnect
);

	logic [8:0] sum;
	logic [7:0] vol_up;
	logic [7:0] vol_down;
	logic [7:0] vol;
	logic       mute;
	logic       apply;
	logic       ok;
	logic       vol_chg;
	logic       any_chg;

	// saturating relative steps
	assign sum      = {1'b0, cur.volume} + {1'b0, step_size};
	assign vol_up   = sum[8] ? vcp_pkg::VOL_MAX : sum[7:0];
	assign vol_down = (cur.volume > step_size) ? (cur.volume - step_size) : 8'd0;

	always_comb begin
		nxt              = cur;
		res.status       = vcp_pkg::ST_OK;
		res.notify_state = 1'b0;
		res.notify_flags = 1'b0;
		res.event_valid  = 1'b0;
		vol              = cur.volume;
		mute             = cur.muted;
		apply            = 1'b0;
		ok               = 1'b1;
		disconnect       = 1'b0;

		case (item.cmd)
			vcp_pkg::CMD_REMOTE: begin
				if (item.length < vcp_pkg::LEN_MIN) begin
					res.status = vcp_pkg::ST_NOT_SUPPORTED;
				end else if (item.client_counter != cur.count) begin
					res.status = vcp_pkg::ST_BAD_COUNTER;
				end else begin
					case (item.opcode)
						vcp_pkg::OP_REL_DOWN: vol = vol_down;
						vcp_pkg::OP_REL_UP: vol = vol_up;
						vcp_pkg::OP_UNMUTE_REL_DOWN: begin
							vol  = vol_down;
							mute = 1'b0;
						end
						vcp_pkg::OP_UNMUTE_REL_UP: begin
							vol  = vol_up;
							mute = 1'b0;
						end
						vcp_pkg::OP_SET_ABS: begin
							if (item.length != vcp_pkg::LEN_ABS_SET) ok = 1'b0;
							else vol = item.operand;
						end
						vcp_pkg::OP_UNMUTE: mute = 1'b0;
						vcp_pkg::OP_MUTE: mute = 1'b1;
						default: ok = 1'b0;
					endcase
					if (ok) begin
						apply           = 1'b1;
						res.event_valid = 1'b1;
					end else begin
						res.status = vcp_pkg::ST_NOT_SUPPORTED;
					end
				end
			end
			vcp_pkg::CMD_LOCAL: begin
				vol   = item.operand;
				mute  = item.local_mute;
				apply = 1'b1;
			end
			vcp_pkg::CMD_DISCONNECT: begin
				nxt.volume  = 8'd0;
				nxt.muted   = 1'b0;
				nxt.persist = 1'b0;
				disconnect  = 1'b1;
			end
			default: ;
		endcase

		vol_chg = (vol != cur.volume);
		any_chg = vol_chg || (mute != cur.muted);

		if (apply) begin
			nxt.volume = vol;
			nxt.muted  = mute;
			if (any_chg) begin
				nxt.count        = cur.count + 8'd1;
				res.notify_state = notify_en;
			end
			if (vol_chg && !cur.persist) begin
				nxt.persist      = 1'b1;
				res.notify_flags = notify_en;
			end
		end

		res.st = nxt;
	end

endmodule

`default_nettype wire

// ===== hdl/volume_control_point_engine_top.sv =====
// Top level of the volume control point engine: input stage, state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// -------   ---------------------   ------------------------------------------------
// input     in_valid / in_ready     cmd, opcode, client_counter, operand, length,
//                                   local_mute
// result    out_valid / out_ready   status, volume, muted, change_count,
//                                   persisted_flag, notify_state, notify_flags,
//                                   event_valid
// config    cfg_we (no wait)        cfg_index, cfg_data
//
// Flow: an item is latched into the input stage, then evaluated combinationally
//   against the state registers and written with the new state into the result
//   register; throughput is one item per cycle while the output does not stall.
// The state is updated as the item leaves the input stage, so the next item
//   always sees the state its predecessor left.
// Reset clears state and both valid flags and returns the config registers to their defaults; no clearing pass.
// A stall at the output holds the result and then the input stage; in_ready
//   stays high while the input stage is empty or moving.

module volume_control_point_engine_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input items
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic [7:0] opcode,
	input  wire logic [7:0] client_counter,
	input  wire logic [7:0] operand,
	input  wire logic [2:0] length,
	input  wire logic       local_mute,
	// result items
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      status,
	output logic [7:0]      volume,
	output logic            muted,
	output logic [7:0]      change_count,
	output logic            persisted_flag,
	output logic            notify_state,
	output logic            notify_flags,
	output logic            event_valid,
	// configuration
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	vcp_pkg::vcp_item_t   item_s1;
	logic                 valid_s1;
	vcp_pkg::vcp_state_t  state_q;
	vcp_pkg::vcp_state_t  state_nxt;
	vcp_pkg::vcp_result_t res_nxt;
	vcp_pkg::vcp_result_t res_q;
	logic                 out_valid_q;
	logic [7:0]           step_size_q;
	logic                 notify_en_q;
	logic                 disconnect;
	logic                 advance;

	// item moves from the input stage into the result register
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd            <= cmd;
			item_s1.opcode         <= opcode;
			item_s1.client_counter <= client_counter;
			item_s1.operand        <= operand;
			item_s1.length         <= length;
			item_s1.local_mute     <= local_mute;
		end
	end

	vcp_calc u_calc (
		.cur        (state_q),
		.item       (item_s1),
		.step_size  (step_size_q),
		.notify_en  (notify_en_q),
		.nxt        (state_nxt),
		.res        (res_nxt),
		.disconnect (disconnect)
	);

	// persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// config registers; a disconnect drops the subscription and the step size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= vcp_pkg::STEP_RESET;
			notify_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				vcp_pkg::CFG_STEP_SIZE: step_size_q <= cfg_data;
				vcp_pkg::CFG_NOTIFY_EN: notify_en_q <= cfg_data[0];
				default: ;
			endcase
		end else if (advance && disconnect) begin
			step_size_q <= vcp_pkg::STEP_RESET;
			notify_en_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign volume         = res_q.st.volume;
	assign muted          = res_q.st.muted;
	assign change_count   = res_q.st.count;
	assign persisted_flag = res_q.st.persist;
	assign notify_state   = res_q.notify_state;
	assign notify_flags   = res_q.notify_flags;
	assign event_valid    = res_q.event_valid;

	// requests are raised only for a subscribed client
	a_notify_needs_sub: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res_nxt.notify_state || res_nxt.notify_flags) |-> notify_en_q)
		else $error("notification request without subscription");

	// an error leaves the state untouched
	a_error_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res_nxt.status != vcp_pkg::ST_OK) |=> state_q == $past(state_q))
		else $error("state changed on an error status");

	// the change counter only ever steps by one
	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.count != $past(state_q.count) |->
		state_q.count == $past(state_q.count) + 8'd1)
		else $error("change counter jumped");

	// a reported event is always a success
	a_event_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.event_valid |-> res_q.status == vcp_pkg::ST_OK)
		else $error("event on a failed write");

	// a flags request only comes with the persisted flag set
	a_flags_persist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.notify_flags |-> res_q.st.persist)
		else $error("flags request without persisted flag");

endmodule

`default_nettype wire

// ===== dv/tb_volume_control_point_engine_top.sv =====
// Self-checking testbench for the volume control point engine: directed and random items.
`timescale 1ns / 1ps

module tb_volume_control_point_engine_top;

	// Command code with no meaning to the block; it must leave the state alone.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// Lowest opcode the control point does not define.
	localparam logic [7:0] OP_FIRST_UNDEFINED = 8'd7;
	// Cycles with no item moved on either channel before the run is abandoned.
	localparam int unsigned STALL_LIMIT = 2000;
	// Length of the long receiver hold-off that backs the block up.
	localparam int unsigned HOLD_CYCLES = 64;
	// Wait after the last drain before results are counted as missing.
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned ITEMS_PER_PHASE = 280;
	localparam int unsigned PHASES = 5;
	localparam int unsigned MAX_REPORTS = 10;

	// How the driver fills in client_counter when it puts an item on the bus.
	// The change counter the block holds depends on every earlier item, so a
	// well-formed write can only be built once its predecessors are accepted.
	typedef enum logic [1:0] {
		CTR_KEEP,    // use the random value staged with the item
		CTR_CURRENT, // copy the counter the block holds right now
		CTR_STALE    // counter the block holds, plus a nonzero offset
	} ctr_fill_t;

	typedef struct {
		vcp_pkg::vcp_item_t item;
		ctr_fill_t          fill;
	} staged_item_t;

	// Receiver behavior over one segment of cycles.
	typedef enum logic [1:0] {
		RX_OPEN,   // always ready
		RX_JITTER, // ready half of the time
		RX_CHOKE   // ready one cycle in eight
	} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] cmd = '0;
	logic [7:0] opcode = '0;
	logic [7:0] client_counter = '0;
	logic [7:0] operand = '0;
	logic [2:0] length = '0;
	logic       local_mute = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	logic [7:0] volume;
	logic       muted;
	logic [7:0] change_count;
	logic       persisted_flag;
	logic       notify_state;
	logic       notify_flags;
	logic       event_valid;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;

	volume_control_point_engine_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.opcode        (opcode),
		.client_counter(client_counter),
		.operand       (operand),
		.length        (length),
		.local_mute    (local_mute),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.volume        (volume),
		.muted         (muted),
		.change_count  (change_count),
		.persisted_flag(persisted_flag),
		.notify_state  (notify_state),
		.notify_flags  (notify_flags),
		.event_valid   (event_valid),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow of the block: volume state plus its two config registers.
	// Advanced once per accepted item, at the edge that accepts it.
	// ------------------------------------------------------------------
	logic [7:0] sh_volume = '0;
	logic       sh_muted = 1'b0;
	logic [7:0] sh_count = '0;
	logic       sh_persist = 1'b0;
	logic [7:0] sh_step = vcp_pkg::STEP_RESET;
	logic       sh_notify_en = 1'b0;

	staged_item_t          cmd_backlog[$];      // items waiting for the driver
	vcp_pkg::vcp_result_t  expected_reports[$]; // predicted results, oldest first

	// Bookkeeping for the checker and the closing summary
	int unsigned score_errors = 0;
	int unsigned idle_cycles = 0;
	int unsigned n_items = 0;
	int unsigned n_results = 0;
	int unsigned n_ok = 0;
	int unsigned n_unsupported = 0;
	int unsigned n_bad_counter = 0;
	int unsigned n_state_req = 0;
	int unsigned n_flag_req = 0;
	int unsigned n_holds = 0;

	logic         in_taken = 1'b0; // item accepted at the last rising edge
	staged_item_t next_up;

	// Sender burst shaping
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	// Receiver pattern and long hold-off
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned seg_left = 0;
	int unsigned hold_left = 0;
	logic        hold_start = 1'b0;

	// Apply a new volume and mute to the shadow. The counter steps on any
	// change; the first volume change after reset or disconnect marks the
	// setting as persisted. Requests only go out while a client listens.
	function automatic void settle_state(input logic [7:0] nv, input logic nm,
			inout vcp_pkg::vcp_result_t r);
		logic vol_moved;
		vol_moved = (nv != sh_volume);
		if (vol_moved || (nm != sh_muted)) begin
			sh_count = sh_count + 8'd1;
			r.notify_state = sh_notify_en;
		end
		if (vol_moved && !sh_persist) begin
			sh_persist = 1'b1;
			r.notify_flags = sh_notify_en;
		end
		sh_volume = nv;
		sh_muted = nm;
	endfunction

	// Work out the result of one item and advance the shadow state.
	function automatic vcp_pkg::vcp_result_t advance_volume_state(
			input vcp_pkg::vcp_item_t it);
		vcp_pkg::vcp_result_t r;
		logic [8:0]  sum;
		logic [7:0]  vol_up;
		logic [7:0]  vol_dn;
		logic [7:0]  nv;
		logic        nm;
		logic        known;
		r = '0;
		r.status = vcp_pkg::ST_OK;
		sum = {1'b0, sh_volume} + {1'b0, sh_step};
		vol_up = (sum > {1'b0, vcp_pkg::VOL_MAX}) ? vcp_pkg::VOL_MAX : sum[7:0];
		vol_dn = (sh_volume > sh_step) ? (sh_volume - sh_step) : 8'd0;
		case (it.cmd)
			vcp_pkg::CMD_REMOTE: begin
				// length is checked first, then the counter, then the opcode
				if (it.length < vcp_pkg::LEN_MIN) begin
					r.status = vcp_pkg::ST_NOT_SUPPORTED;
				end else if (it.client_counter != sh_count) begin
					r.status = vcp_pkg::ST_BAD_COUNTER;
				end else begin
					nv = sh_volume;
					nm = sh_muted;
					known = 1'b1;
					case (it.opcode)
						vcp_pkg::OP_REL_DOWN: nv = vol_dn;
						vcp_pkg::OP_REL_UP: nv = vol_up;
						vcp_pkg::OP_UNMUTE_REL_DOWN: begin
							nv = vol_dn;
							nm = 1'b0;
						end
						vcp_pkg::OP_UNMUTE_REL_UP: begin
							nv = vol_up;
							nm = 1'b0;
						end
						vcp_pkg::OP_SET_ABS: begin
							if (it.length == vcp_pkg::LEN_ABS_SET) nv = it.operand;
							else known = 1'b0;
						end
						vcp_pkg::OP_UNMUTE: nm = 1'b0;
						vcp_pkg::OP_MUTE: nm = 1'b1;
						default: known = 1'b0;
					endcase
					if (known) begin
						settle_state(nv, nm, r);
						r.event_valid = 1'b1;
					end else begin
						r.status = vcp_pkg::ST_NOT_SUPPORTED;
					end
				end
			end
			vcp_pkg::CMD_LOCAL: settle_state(it.operand, it.local_mute, r);
			vcp_pkg::CMD_DISCONNECT: begin
				// counter survives; the subscription and step size do not
				sh_volume = '0;
				sh_muted = 1'b0;
				sh_persist = 1'b0;
				sh_step = vcp_pkg::STEP_RESET;
				sh_notify_en = 1'b0;
			end
			default: ;
		endcase
		r.st.volume = sh_volume;
		r.st.muted = sh_muted;
		r.st.count = sh_count;
		r.st.persist = sh_persist;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: checks results, predicts accepted items, runs the watchdog.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		vcp_pkg::vcp_result_t got;
		vcp_pkg::vcp_result_t want;
		vcp_pkg::vcp_item_t   seen;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.status = status;
				got.st.volume = volume;
				got.st.muted = muted;
				got.st.count = change_count;
				got.st.persist = persisted_flag;
				got.notify_state = notify_state;
				got.notify_flags = notify_flags;
				got.event_valid = event_valid;
				n_results++;
				if (expected_reports.size() == 0) begin
					score_errors++;
					if (score_errors <= MAX_REPORTS)
						$display("%0t: result with nothing expected: st=%0d vol=%0d cnt=%0d",
							$realtime, got.status, got.st.volume, got.st.count);
				end else begin
					want = expected_reports.pop_front();
					// packed compare covers every field, X and Z included
					if (got !== want) begin
						score_errors++;
						if (score_errors <= MAX_REPORTS) begin
							$display("%0t: result %0d differs", $realtime, n_results);
							$display("  exp st=%0d vol=%0d mute=%0b cnt=%0d pers=%0b ns=%0b nf=%0b ev=%0b",
								want.status, want.st.volume, want.st.muted, want.st.count,
								want.st.persist, want.notify_state, want.notify_flags,
								want.event_valid);
							$display("  got st=%0d vol=%0d mute=%0b cnt=%0d pers=%0b ns=%0b nf=%0b ev=%0b",
								got.status, got.st.volume, got.st.muted, got.st.count,
								got.st.persist, got.notify_state, got.notify_flags,
								got.event_valid);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				seen.cmd = cmd;
				seen.opcode = opcode;
				seen.client_counter = client_counter;
				seen.operand = operand;
				seen.length = length;
				seen.local_mute = local_mute;
				want = advance_volume_state(seen);
				expected_reports.push_back(want);
				n_items++;
				case (want.status)
					vcp_pkg::ST_OK: n_ok++;
					vcp_pkg::ST_NOT_SUPPORTED: n_unsupported++;
					default: n_bad_counter++;
				endcase
				n_state_req += want.notify_state;
				n_flag_req += want.notify_flags;
			end
			// watchdog: only counts while work is outstanding
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else if (in_valid || cmd_backlog.size() != 0 || expected_reports.size() != 0) begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("%0t: no item moved for %0d cycles", $realtime, idle_cycles);
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
		in_taken = in_valid && in_ready;
	end

	// ------------------------------------------------------------------
	// Driver: bursts of items with random gaps. Holds an item until it
	// is taken; the counter of a well-formed write is filled in here,
	// once the shadow has seen every earlier item.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!(in_valid && !in_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				next_up = cmd_backlog.pop_front();
				case (next_up.fill)
					CTR_CURRENT: next_up.item.client_counter = sh_count;
					CTR_STALE:
						next_up.item.client_counter = sh_count + 8'($urandom_range(1, 255));
					default: ;
				endcase
				cmd <= next_up.item.cmd;
				opcode <= next_up.item.opcode;
				client_counter <= next_up.item.client_counter;
				operand <= next_up.item.operand;
				length <= next_up.item.length;
				local_mute <= next_up.item.local_mute;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					// new burst; a quarter of them run straight on with no gap
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: segments of open, jittery or choked acceptance, and on
	// request one long hold-off counted here.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_start) begin
			hold_start = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			n_holds++;
			out_ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				seg_left = $urandom_range(8, 60);
			end
			seg_left--;
			case (rx_mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_JITTER: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic void stage(input logic [1:0] c, input logic [7:0] op,
			input logic [2:0] len, input logic [7:0] val, input logic lm, input ctr_fill_t f);
		staged_item_t s;
		s.item.cmd = c;
		s.item.opcode = op;
		s.item.client_counter = 8'($urandom);
		s.item.operand = val;
		s.item.length = len;
		s.item.local_mute = lm;
		s.fill = f;
		cmd_backlog.push_back(s);
	endfunction

	// Mostly well-formed control writes, with short writes, stale
	// counters, undefined opcodes, local sets and rare disconnects mixed in.
	function automatic void stage_random_item();
		int unsigned pick;
		logic [7:0]  op;
		logic [2:0]  len;
		pick = $urandom_range(0, 99);
		op = 8'($urandom_range(0, 6));
		len = 3'($urandom_range(2, 7));
		if (op == vcp_pkg::OP_SET_ABS && $urandom_range(0, 7) != 0) len = vcp_pkg::LEN_ABS_SET;
		if (pick < 70)
			stage(vcp_pkg::CMD_REMOTE, op, len, 8'($urandom), 1'($urandom), CTR_CURRENT);
		else if (pick < 76)
			stage(vcp_pkg::CMD_REMOTE, op, 3'($urandom_range(0, 1)), 8'($urandom),
				1'($urandom), ($urandom_range(0, 1) != 0) ? CTR_CURRENT : CTR_KEEP);
		else if (pick < 81)
			stage(vcp_pkg::CMD_REMOTE, op, len, 8'($urandom), 1'($urandom), CTR_STALE);
		else if (pick < 86)
			stage(vcp_pkg::CMD_REMOTE, 8'($urandom_range(OP_FIRST_UNDEFINED, 255)), len,
				8'($urandom), 1'($urandom), CTR_CURRENT);
		else if (pick < 96)
			stage(vcp_pkg::CMD_LOCAL, 8'($urandom), 3'($urandom), 8'($urandom), 1'($urandom),
				CTR_KEEP);
		else if (pick < 98)
			stage(CMD_UNUSED, 8'($urandom), 3'($urandom), 8'($urandom), 1'($urandom), CTR_KEEP);
		else
			stage(vcp_pkg::CMD_DISCONNECT, 8'($urandom), 3'($urandom), 8'($urandom),
				1'($urandom), CTR_KEEP);
	endfunction

	// Sender stops until every item is taken and every result is back.
	task automatic drain_backlog();
		while (cmd_backlog.size() != 0 || in_valid || expected_reports.size() != 0)
			@(negedge clk);
	endtask

	// Register write, only ever issued with the block idle.
	task automatic set_register(input logic idx, input logic [7:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == vcp_pkg::CFG_STEP_SIZE) sh_step = data;
		else sh_notify_en = data[0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: unit step, client subscribed. Upper data bits of the
		// enable write are junk on purpose, only bit 0 counts.
		set_register(vcp_pkg::CFG_STEP_SIZE, vcp_pkg::STEP_RESET);
		set_register(vcp_pkg::CFG_NOTIFY_EN, {7'($urandom), 1'b1});
		// short write, empty
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_REL_UP, 3'd0, 8'd0, 1'b0, CTR_KEEP);
		// short write, one byte
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_REL_UP, 3'd1, 8'd0, 1'b0, CTR_CURRENT);
		// counter mismatch
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_REL_UP, 3'd2, 8'd0, 1'b0, CTR_STALE);
		// floor, no change
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_REL_DOWN, 3'd2, 8'd0, 1'b0, CTR_CURRENT);
		// already unmuted
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_UNMUTE, 3'd2, 8'd0, 1'b0, CTR_CURRENT);
		// first change, flags
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_REL_UP, 3'd2, 8'd0, 1'b0, CTR_CURRENT);
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_SET_ABS, vcp_pkg::LEN_ABS_SET, vcp_pkg::VOL_MAX,
			1'b0, CTR_CURRENT);
		// ceiling, no change
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_REL_UP, 3'd7, 8'd0, 1'b0, CTR_CURRENT);
		// absolute too short
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_SET_ABS, 3'd2, 8'd9, 1'b0, CTR_CURRENT);
		// absolute too long
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_SET_ABS, 3'd7, 8'd9, 1'b0, CTR_CURRENT);
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_MUTE, 3'd2, 8'd0, 1'b0, CTR_CURRENT);
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_UNMUTE_REL_DOWN, 3'd2, 8'd0, 1'b0, CTR_CURRENT);
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_MUTE, 3'd3, 8'd0, 1'b0, CTR_CURRENT);
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_UNMUTE_REL_UP, 3'd4, 8'd0, 1'b0, CTR_CURRENT);
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_SET_ABS, vcp_pkg::LEN_ABS_SET, 8'd0, 1'b1,
			CTR_CURRENT);
		stage(vcp_pkg::CMD_REMOTE, OP_FIRST_UNDEFINED, 3'd2, 8'd0, 1'b0, CTR_CURRENT);
		stage(vcp_pkg::CMD_REMOTE, 8'hFF, 3'd3, 8'hFF, 1'b1, CTR_CURRENT);
		stage(vcp_pkg::CMD_LOCAL, 8'd0, 3'd0, 8'h80, 1'b1, CTR_KEEP);     // local set
		stage(vcp_pkg::CMD_LOCAL, 8'd0, 3'd0, 8'h80, 1'b1, CTR_KEEP);     // same again
		stage(CMD_UNUSED, 8'($urandom), 3'($urandom), 8'($urandom), 1'b1, CTR_KEEP);
		stage(vcp_pkg::CMD_DISCONNECT, 8'd0, 3'd0, 8'd0, 1'b0, CTR_KEEP);
		// no subscriber now
		stage(vcp_pkg::CMD_REMOTE, vcp_pkg::OP_REL_UP, 3'd2, 8'd0, 1'b0, CTR_CURRENT);
		stage(vcp_pkg::CMD_LOCAL, 8'd0, 3'd0, 8'd0, 1'b0, CTR_KEEP);
		drain_backlog();

		// Random phases across step and subscription settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					set_register(vcp_pkg::CFG_STEP_SIZE, vcp_pkg::VOL_MAX);
					set_register(vcp_pkg::CFG_NOTIFY_EN, 8'd1);
				end
				1: begin
					set_register(vcp_pkg::CFG_STEP_SIZE, 8'd0);
					set_register(vcp_pkg::CFG_NOTIFY_EN, 8'd1);
				end
				2: begin
					set_register(vcp_pkg::CFG_STEP_SIZE, 8'($urandom_range(2, 254)));
					set_register(vcp_pkg::CFG_NOTIFY_EN, {7'($urandom), 1'b0});
				end
				3: begin
					set_register(vcp_pkg::CFG_STEP_SIZE, 8'($urandom_range(1, 16)));
					set_register(vcp_pkg::CFG_NOTIFY_EN, 8'd1);
				end
				default: begin
					set_register(vcp_pkg::CFG_STEP_SIZE, 8'($urandom));
					set_register(vcp_pkg::CFG_NOTIFY_EN, 8'd1);
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) stage_random_item();
			if (p == 3) begin
				// back the block up while the sender keeps offering
				@(posedge clk);
				hold_start = 1'b1;
			end
			drain_backlog();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_reports.size() != 0) begin
			score_errors++;
			$display("%0d results never arrived", expected_reports.size());
		end
		$display("covered %0d items / %0d results: %0d ok, %0d unsupported, %0d bad counter",
			n_items, n_results, n_ok, n_unsupported, n_bad_counter);
		$display("  %0d state and %0d flag requests, %0d long hold-offs, %0d errors",
			n_state_req, n_flag_req, n_holds, score_errors);
		if (score_errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
